// ===== design/bitmap_page_allocator_defines.svh =====
// ----------------------------------------------------------------------------
// Bitmap page allocator assertion macros
// Shared assertion macros for the page allocator, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef BITMAP_PAGE_ALLOCATOR_DEFINES_SVH
`define BITMAP_PAGE_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define BPA_ASSERT_IMP(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
`define BPA_ASSERT_NXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define BPA_ASSERT_IMP(label, clk, rst_n, pre, post, msg)
`define BPA_ASSERT_NXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// ===== design/bpa_pkg.sv =====
// ----------------------------------------------------------------------------
// Bitmap page allocator package
// Field widths, codes and the request structures shared by all modules.
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int KIND_W        = 2;
    localparam int COUNT_W       = 7;
    localparam int PAGE_W        = 12;
    localparam int TOTAL_W       = 13;
    localparam int STATUS_W      = 2;
    localparam int MAP_BITS      = 8;
    localparam int BIT_W         = 3;
    localparam int IN_DATA_W     = 24;
    localparam int OUT_DATA_W    = 32;
    localparam int CFG_ADDR_W    = 1;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = 1;
    localparam int QCNT_W        = 2;
    localparam int MAX_PAGES_DEF = 4096;
    localparam int MAX_BURST_DEF = 64;
    localparam int TOTAL_RST     = 4096;
    localparam int RESERVED_RST  = 0;

    typedef enum logic [KIND_W-1:0] {
        KIND_INIT  = 2'd0,
        KIND_ALLOC = 2'd1,
        KIND_FREE  = 2'd2
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_RANGE   = 2'd2
    } t_status;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_TOTAL    = 1'd0,
        REG_RESERVED = 1'd1
    } t_reg;

    typedef enum logic [1:0] {
        OP_INIT,
        OP_ALLOC,
        OP_FREE,
        OP_REJECT
    } t_op;

    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic [TOTAL_W-1:0] reserved;
    } t_cfg;

    typedef struct packed {
        t_op                op;
        t_status            status;
        logic [COUNT_W-1:0] count;
        logic [PAGE_W-1:0]  page;
    } t_cmd;

endpackage

// ===== design/bpa_front.sv =====
// ----------------------------------------------------------------------------
// Bitmap page allocator front end
// Holds the configuration registers, accepts requests and sorts them into
// commands for the map engine.
// ----------------------------------------------------------------------------
module bpa_front #(
    parameter int MAX_PAGES = bpa_pkg::MAX_PAGES_DEF,
    parameter int MAX_BURST = bpa_pkg::MAX_BURST_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bpa_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [bpa_pkg::TOTAL_W-1:0]       i_cfg_wdata,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [bpa_pkg::KIND_W-1:0]        i_kind,
    input  logic [bpa_pkg::COUNT_W-1:0]       i_page_count,
    input  logic [bpa_pkg::PAGE_W-1:0]        i_free_page,
    input  logic                              i_q_full,
    input  logic                              i_map_ready,
    output logic                              o_push,
    output bpa_pkg::t_cmd                     o_cmd,
    output bpa_pkg::t_cfg                     o_cfg
);

    localparam int TOTAL_MAX = (1 << bpa_pkg::TOTAL_W) - 1;
    localparam int CAP_I     = (MAX_PAGES > TOTAL_MAX) ? TOTAL_MAX : MAX_PAGES;
    localparam logic [bpa_pkg::TOTAL_W-1:0] CAP = bpa_pkg::TOTAL_W'(CAP_I);
    localparam logic [bpa_pkg::COUNT_W-1:0] BURST = bpa_pkg::COUNT_W'(MAX_BURST);

    logic [bpa_pkg::TOTAL_W-1:0] r_total;
    logic [bpa_pkg::TOTAL_W-1:0] r_reserved;
    logic [bpa_pkg::TOTAL_W-1:0] eff_total;
    logic                        kind_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total    <= bpa_pkg::TOTAL_W'(bpa_pkg::TOTAL_RST);
            r_reserved <= bpa_pkg::TOTAL_W'(bpa_pkg::RESERVED_RST);
        end else if (i_cfg_we) begin
            unique case (bpa_pkg::t_reg'(i_cfg_addr))
                bpa_pkg::REG_TOTAL:    r_total    <= i_cfg_wdata;
                bpa_pkg::REG_RESERVED: r_reserved <= i_cfg_wdata;
            endcase
        end
    end

    always_comb begin
        eff_total      = (r_total < CAP) ? r_total : CAP;
        o_cfg.total    = eff_total;
        o_cfg.reserved = (r_reserved < eff_total) ? r_reserved : eff_total;
    end

    always_comb begin
        kind_ok      = 1'b1;
        o_cmd.op     = bpa_pkg::OP_REJECT;
        o_cmd.status = bpa_pkg::ST_OK;
        o_cmd.count  = i_page_count;
        o_cmd.page   = i_free_page;
        unique case (bpa_pkg::t_kind'(i_kind))
            bpa_pkg::KIND_INIT: begin
                o_cmd.op = bpa_pkg::OP_INIT;
            end
            bpa_pkg::KIND_ALLOC: begin
                if (i_page_count == '0) begin
                    o_cmd.op = bpa_pkg::OP_REJECT;
                end else if (i_page_count > BURST) begin
                    o_cmd.status = bpa_pkg::ST_NOSPACE;
                end else begin
                    o_cmd.op = bpa_pkg::OP_ALLOC;
                end
            end
            bpa_pkg::KIND_FREE: begin
                if ({1'b0, i_free_page} >= eff_total) begin
                    o_cmd.status = bpa_pkg::ST_RANGE;
                end else begin
                    o_cmd.op = bpa_pkg::OP_FREE;
                end
            end
            default: begin
                kind_ok = 1'b0;
            end
        endcase
    end

    // Requests of the unused kind are taken and dropped.
    assign o_s_tready = !i_q_full && i_map_ready;
    assign o_push     = i_s_tvalid && o_s_tready && kind_ok;

endmodule

// ===== design/bpa_queue.sv =====
// ----------------------------------------------------------------------------
// Bitmap page allocator command queue
// Two-entry queue that decouples request intake from the map engine.
// ----------------------------------------------------------------------------
module bpa_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bpa_pkg::t_cmd i_data,
    input  logic          i_pop,
    output logic          o_valid,
    output bpa_pkg::t_cmd o_data,
    output logic          o_full
);

    bpa_pkg::t_cmd                r_slot [0:bpa_pkg::QUEUE_DEPTH-1];
    logic [bpa_pkg::QPTR_W-1:0]   r_wp;
    logic [bpa_pkg::QPTR_W-1:0]   r_rp;
    logic [bpa_pkg::QCNT_W-1:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_data;
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == bpa_pkg::QCNT_W'(bpa_pkg::QUEUE_DEPTH));
    assign o_data  = r_slot[r_rp];

endmodule

// ===== design/bpa_back.sv =====
// ----------------------------------------------------------------------------
// Bitmap page allocator map engine
// Keeps the page bitmap in a byte-wide memory, scans it for free pages,
// handles init and free requests and holds the result register.
// ----------------------------------------------------------------------------
module bpa_back #(
    parameter int MAX_PAGES = bpa_pkg::MAX_PAGES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bpa_pkg::t_cfg                 i_cfg,
    input  logic                          i_cmd_valid,
    input  bpa_pkg::t_cmd                 i_cmd,
    output logic                          o_cmd_pop,
    output logic                          o_map_ready,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output bpa_pkg::t_status              o_status,
    output logic                          o_page_valid,
    output logic [bpa_pkg::PAGE_W-1:0]    o_page_number,
    output logic                          o_last,
    output logic [bpa_pkg::TOTAL_W-1:0]   o_free_count
);

    localparam int MB        = bpa_pkg::MAP_BITS;
    localparam int BW        = bpa_pkg::BIT_W;
    localparam int TW        = bpa_pkg::TOTAL_W;
    localparam int MAP_WORDS = (MAX_PAGES + MB - 1) / MB;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int PW        = ((AW + BW > TW) ? AW + BW : TW) + 1;
    localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);
    localparam int FREE_RST_I =
        (MAX_PAGES < bpa_pkg::TOTAL_RST) ? MAX_PAGES : bpa_pkg::TOTAL_RST;
    localparam logic [TW-1:0] FREE_RST = TW'(FREE_RST_I);

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_RD,
        S_CHK,
        S_FRD,
        S_FWR,
        S_RESP
    } t_state;

    t_state                        r_state;
    logic [MB-1:0]                 r_map [0:MAP_WORDS-1];
    logic [MB-1:0]                 r_rdata;
    logic [MB-1:0]                 r_word;
    logic                          r_fresh;
    logic [AW-1:0]                 r_widx;
    logic [BW-1:0]                 r_bit;
    logic [TW-1:0]                 r_sweep_res;
    logic                          r_is_init;
    logic                          r_ready;
    logic [TW-1:0]                 r_free;
    logic [bpa_pkg::COUNT_W-1:0]   r_left;
    bpa_pkg::t_status              r_resp;
    logic                          r_ov;
    bpa_pkg::t_status              r_status;
    logic                          r_pv;
    logic [bpa_pkg::PAGE_W-1:0]    r_page;
    logic                          r_last;
    logic [TW-1:0]                 r_fc;

    logic [MB-1:0]                 cur_word;
    logic [MB-1:0]                 avail;
    logic [MB-1:0]                 sweep_word;
    logic [MB-1:0]                 n_word;
    logic [BW-1:0]                 sel;
    logic                          any_free;
    logic                          past_end;
    logic [PW-1:0]                 base;
    logic [PW-1:0]                 total_x;
    logic [PW-1:0]                 res_x;
    logic [PW-1:0]                 page_full;
    logic [TW-1:0]                 free_dec;
    logic                          slot;
    logic                          mem_we;
    logic [MB-1:0]                 mem_wd;

    always_comb begin
        cur_word = r_fresh ? r_rdata : r_word;
        base     = PW'(r_widx) << BW;
        total_x  = PW'(i_cfg.total);
        res_x    = PW'(r_sweep_res);
        sel      = '0;
        for (int b = 0; b < MB; b++) begin
            avail[b]      = !cur_word[b] && ((base + PW'(b)) < total_x);
            sweep_word[b] = (base + PW'(b)) < res_x;
        end
        for (int b = MB - 1; b >= 0; b--) begin
            if (avail[b]) begin
                sel = BW'(b);
            end
        end
        any_free  = |avail;
        past_end  = (base + PW'(MB)) >= total_x;
        n_word    = cur_word | (MB'(1) << sel);
        page_full = base + PW'(sel);
        free_dec  = (r_free == '0) ? '0 : r_free - 1'b1;
        slot      = !r_ov || i_m_tready;
    end

    always_comb begin
        mem_we = 1'b0;
        mem_wd = sweep_word;
        unique case (r_state)
            S_SWEEP: begin
                mem_we = 1'b1;
            end
            S_CHK: begin
                mem_we = any_free && slot;
                mem_wd = n_word;
            end
            S_FWR: begin
                mem_we = 1'b1;
                mem_wd = r_rdata & ~(MB'(1) << r_bit);
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_map[r_widx] <= mem_wd;
        end
        r_rdata <= r_map[r_widx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_widx      <= '0;
            r_sweep_res <= '0;
            r_is_init   <= 1'b0;
            r_ready     <= 1'b0;
            r_free      <= FREE_RST;
            r_ov        <= 1'b0;
        end else begin
            if (r_ov && i_m_tready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_SWEEP: begin
                    r_widx <= r_widx + 1'b1;
                    if (r_widx == LAST_WORD) begin
                        r_widx <= '0;
                        if (r_is_init) begin
                            r_free  <= i_cfg.total - i_cfg.reserved;
                            r_resp  <= bpa_pkg::ST_OK;
                            r_state <= S_RESP;
                        end else begin
                            r_ready <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_left <= i_cmd.count;
                        r_resp <= i_cmd.status;
                        unique case (i_cmd.op)
                            bpa_pkg::OP_INIT: begin
                                r_sweep_res <= i_cfg.reserved;
                                r_is_init   <= 1'b1;
                                r_widx      <= '0;
                                r_state     <= S_SWEEP;
                            end
                            bpa_pkg::OP_ALLOC: begin
                                if (r_free < TW'(i_cmd.count)) begin
                                    r_resp  <= bpa_pkg::ST_NOSPACE;
                                    r_state <= S_RESP;
                                end else begin
                                    r_widx  <= '0;
                                    r_state <= S_RD;
                                end
                            end
                            bpa_pkg::OP_FREE: begin
                                r_widx  <= AW'(PW'(i_cmd.page) >> BW);
                                r_bit   <= i_cmd.page[BW-1:0];
                                r_state <= S_FRD;
                            end
                            bpa_pkg::OP_REJECT: begin
                                r_state <= S_RESP;
                            end
                        endcase
                    end
                end
                S_RD: begin
                    r_fresh <= 1'b1;
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    r_fresh <= 1'b0;
                    r_word  <= cur_word;
                    if (any_free) begin
                        if (slot) begin
                            r_word   <= n_word;
                            r_ov     <= 1'b1;
                            r_status <= bpa_pkg::ST_OK;
                            r_pv     <= 1'b1;
                            r_page   <= page_full[bpa_pkg::PAGE_W-1:0];
                            r_last   <= (r_left == bpa_pkg::COUNT_W'(1));
                            r_fc     <= free_dec;
                            r_free   <= free_dec;
                            r_left   <= r_left - 1'b1;
                            if (r_left == bpa_pkg::COUNT_W'(1)) begin
                                r_state <= S_IDLE;
                            end
                        end
                    end else if (past_end) begin
                        if (slot) begin
                            r_ov     <= 1'b1;
                            r_status <= bpa_pkg::ST_NOSPACE;
                            r_pv     <= 1'b0;
                            r_page   <= '0;
                            r_last   <= 1'b1;
                            r_fc     <= r_free;
                            r_state  <= S_IDLE;
                        end
                    end else begin
                        r_widx  <= r_widx + 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_FRD: begin
                    r_state <= S_FWR;
                end
                S_FWR: begin
                    if (r_free < i_cfg.total) begin
                        r_free <= r_free + 1'b1;
                    end
                    r_resp  <= bpa_pkg::ST_OK;
                    r_state <= S_RESP;
                end
                S_RESP: begin
                    if (slot) begin
                        r_ov     <= 1'b1;
                        r_status <= r_resp;
                        r_pv     <= 1'b0;
                        r_page   <= '0;
                        r_last   <= 1'b1;
                        r_fc     <= r_free;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_cmd_pop     = (r_state == S_IDLE) && i_cmd_valid;
    assign o_map_ready   = r_ready;
    assign o_m_tvalid    = r_ov;
    assign o_status      = r_status;
    assign o_page_valid  = r_pv;
    assign o_page_number = r_page;
    assign o_last        = r_last;
    assign o_free_count  = r_fc;

endmodule

// ===== design/bitmap_page_allocator.sv =====
// ----------------------------------------------------------------------------
// Bitmap page allocator
// Page frame allocator over a one-bit-per-page map with init, allocate and
// free requests.
//
//   Channel   Direction  Payload
//   i_s_*     in         tuser: kind[1:0]; tdata: page_count, free_page
//   o_m_*     out        tuser: page_valid; tdata: status, page_number, free_count; tlast: last
//   i_cfg_*   in         index 0 managed page count, index 1 reserved page count
//
// After reset the map is cleared one byte per cycle, MAX_PAGES / 8 bytes in all
// (512 at the default size), while o_s_tready stays low.
// An allocate request reads and checks each map byte in turn from page 0 up to
// the last page handed out, taking one page per check; a free reads and then
// rewrites one map byte; an init sweeps the whole map.
// The map engine handles one request at a time; a two-entry queue takes
// requests while it works, and a full result register stalls the engine.
// ----------------------------------------------------------------------------
`include "bitmap_page_allocator_defines.svh"

module bitmap_page_allocator #(
    parameter int MAX_PAGES = bpa_pkg::MAX_PAGES_DEF,
    parameter int MAX_BURST = bpa_pkg::MAX_BURST_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bpa_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [bpa_pkg::TOTAL_W-1:0]       i_cfg_wdata,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // page_count[6:0], free_page[18:7], zero fill [23:19]
    input  logic [bpa_pkg::IN_DATA_W-1:0]     i_s_tdata,
    // kind[1:0]
    input  logic [bpa_pkg::KIND_W-1:0]        i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // status[1:0], page_number[13:2], free_count[26:14], zero fill [31:27]
    output logic [bpa_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    // page_valid[0]
    output logic                              o_m_tuser,
    output logic                              o_m_tlast
);

    localparam int FILL_W = bpa_pkg::OUT_DATA_W - bpa_pkg::STATUS_W
                            - bpa_pkg::PAGE_W - bpa_pkg::TOTAL_W;

    bpa_pkg::t_cmd                   push_cmd;
    bpa_pkg::t_cmd                   head_cmd;
    bpa_pkg::t_cfg                   cfg;
    logic                            q_push;
    logic                            q_pop;
    logic                            q_valid;
    logic                            q_full;
    logic                            map_ready;
    bpa_pkg::t_status                res_status;
    logic [bpa_pkg::PAGE_W-1:0]      res_page;
    logic [bpa_pkg::TOTAL_W-1:0]     res_free;

    bpa_front #(
        .MAX_PAGES (MAX_PAGES),
        .MAX_BURST (MAX_BURST)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_s_tvalid   (i_s_tvalid),
        .o_s_tready   (o_s_tready),
        .i_kind       (i_s_tuser),
        .i_page_count (i_s_tdata[bpa_pkg::COUNT_W-1:0]),
        .i_free_page  (i_s_tdata[bpa_pkg::COUNT_W +: bpa_pkg::PAGE_W]),
        .i_q_full     (q_full),
        .i_map_ready  (map_ready),
        .o_push       (q_push),
        .o_cmd        (push_cmd),
        .o_cfg        (cfg)
    );

    bpa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (push_cmd),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (head_cmd),
        .o_full  (q_full)
    );

    bpa_back #(
        .MAX_PAGES (MAX_PAGES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_cmd_valid   (q_valid),
        .i_cmd         (head_cmd),
        .o_cmd_pop     (q_pop),
        .o_map_ready   (map_ready),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_status      (res_status),
        .o_page_valid  (o_m_tuser),
        .o_page_number (res_page),
        .o_last        (o_m_tlast),
        .o_free_count  (res_free)
    );

    assign o_m_tdata = {{FILL_W{1'b0}}, res_free, res_page, res_status};

    `BPA_ASSERT_IMP(a_push_not_full, i_clk, i_rst_n, q_push, !q_full,
        "Request queued while the queue is full.")
    `BPA_ASSERT_NXT(a_push_visible, i_clk, i_rst_n, q_push, q_valid,
        "Queued request not visible to the map engine.")
    `BPA_ASSERT_IMP(a_hold_while_clear, i_clk, i_rst_n, !map_ready, !o_s_tready,
        "Request taken before the map clear finished.")
    `BPA_ASSERT_IMP(a_page_ok, i_clk, i_rst_n, o_m_tvalid && o_m_tuser,
        res_status == bpa_pkg::ST_OK,
        "Allocated page reported with a failing status.")

endmodule

// ===== tb/bitmap_page_allocator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap page allocator testbench
// Drives init, allocate and free requests into the allocator and checks every
// response against a behavioral copy of the page map and free count. Directed
// tests cover the field extremes, register extremes, exhaustion and stale-map
// cases. Random traffic then runs over several map settings with bursts of
// idle cycles on both streams in all but the last two settings.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_tb;

    localparam int MAP_PAGES    = 4096;
    localparam int BURST_LIMIT  = 64;
    localparam int DRAIN_CYCLES = 1500;
    localparam int QUIET_LIMIT  = 20000;
    localparam logic [bpa_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [bpa_pkg::STATUS_W-1:0] status;
        logic                         page_valid;
        logic [bpa_pkg::PAGE_W-1:0]   page_number;
        logic                         last;
        logic [bpa_pkg::TOTAL_W-1:0]  free_count;
    } t_page_result;

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_cfg_we    = 1'b0;
    logic [bpa_pkg::CFG_ADDR_W-1:0] i_cfg_addr  = '0;
    logic [bpa_pkg::TOTAL_W-1:0]    i_cfg_wdata = '0;
    logic                           i_s_tvalid  = 1'b0;
    logic                           o_s_tready;
    logic [bpa_pkg::IN_DATA_W-1:0]  i_s_tdata   = '0;
    logic [bpa_pkg::KIND_W-1:0]     i_s_tuser   = '0;
    logic                           o_m_tvalid;
    logic                           i_m_tready  = 1'b0;
    logic [bpa_pkg::OUT_DATA_W-1:0] o_m_tdata;
    logic                           o_m_tuser;
    logic                           o_m_tlast;

    t_page_result page_results_due[$];
    int           held_pages[$];
    bit           page_in_use[MAP_PAGES];
    int           pages_free   = MAP_PAGES;
    int           total_reg    = bpa_pkg::TOTAL_RST;
    int           reserved_reg = bpa_pkg::RESERVED_RST;

    bit           idle_en        = 1'b1;
    int           rx_stall_left  = 0;
    int           quiet_cycles   = 0;
    int           mismatches     = 0;
    int           requests_sent  = 0;
    int           results_seen   = 0;
    int           settings_used  = 0;
    int           directed_count = 0;
    t_page_result want;
    t_page_result seen;

    bitmap_page_allocator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int managed_pages();
        return (total_reg < MAP_PAGES) ? total_reg : MAP_PAGES;
    endfunction

    function automatic void push_result(input logic [bpa_pkg::STATUS_W-1:0] status,
                                        input bit valid, input int page, input bit last);
        t_page_result r;
        r.status      = status;
        r.page_valid  = valid;
        r.page_number = page[bpa_pkg::PAGE_W-1:0];
        r.last        = last;
        r.free_count  = pages_free[bpa_pkg::TOTAL_W-1:0];
        page_results_due.push_back(r);
    endfunction

    function automatic void compute_page_results(input logic [bpa_pkg::KIND_W-1:0] kind,
                                                 input logic [bpa_pkg::COUNT_W-1:0] count,
                                                 input logic [bpa_pkg::PAGE_W-1:0] page);
        int total;
        int rsv;
        int cursor;
        int n;
        bit done;
        total  = managed_pages();
        cursor = 0;
        done   = 1'b0;
        case (kind)
            bpa_pkg::KIND_INIT: begin
                rsv = (reserved_reg < total) ? reserved_reg : total;
                for (int p = 0; p < MAP_PAGES; p++)
                    page_in_use[p] = (p < rsv);
                pages_free = total - rsv;
                held_pages.delete();
                push_result(bpa_pkg::ST_OK, 1'b0, 0, 1'b1);
            end
            bpa_pkg::KIND_ALLOC: begin
                if (count == 0) begin
                    push_result(bpa_pkg::ST_OK, 1'b0, 0, 1'b1);
                end else if (count > BURST_LIMIT || pages_free < count) begin
                    push_result(bpa_pkg::ST_NOSPACE, 1'b0, 0, 1'b1);
                end else begin
                    for (n = 0; n < count && !done; n++) begin
                        while (cursor < total && page_in_use[cursor])
                            cursor++;
                        if (cursor >= total) begin
                            push_result(bpa_pkg::ST_NOSPACE, 1'b0, 0, 1'b1);
                            done = 1'b1;
                        end else begin
                            page_in_use[cursor] = 1'b1;
                            if (pages_free > 0)
                                pages_free--;
                            push_result(bpa_pkg::ST_OK, 1'b1, cursor, n == count - 1);
                            held_pages.push_back(cursor);
                            cursor++;
                        end
                    end
                end
            end
            bpa_pkg::KIND_FREE: begin
                if (page >= total) begin
                    push_result(bpa_pkg::ST_RANGE, 1'b0, 0, 1'b1);
                end else begin
                    page_in_use[page] = 1'b0;
                    if (pages_free < total)
                        pages_free++;
                    push_result(bpa_pkg::ST_OK, 1'b0, 0, 1'b1);
                end
            end
            default: ;
        endcase
    endfunction

    // Valid is left high on return so that a following request can go out at the
    // same edge; anything else that lets time pass lowers it first.
    task automatic send_request(input logic [bpa_pkg::KIND_W-1:0] kind,
                                input logic [bpa_pkg::COUNT_W-1:0] count,
                                input logic [bpa_pkg::PAGE_W-1:0] page);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        compute_page_results(kind, count, page);
        i_s_tuser  <= kind;
        i_s_tdata  <= {{(bpa_pkg::IN_DATA_W - bpa_pkg::PAGE_W - bpa_pkg::COUNT_W){1'b0}},
                       page, count};
        i_s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        requests_sent++;
    endtask

    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (page_results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input int total, input int reserved);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= bpa_pkg::REG_TOTAL;
        i_cfg_wdata <= total[bpa_pkg::TOTAL_W-1:0];
        @(posedge i_clk);
        i_cfg_addr  <= bpa_pkg::REG_RESERVED;
        i_cfg_wdata <= reserved[bpa_pkg::TOTAL_W-1:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        total_reg    = total & 13'h1FFF;
        reserved_reg = reserved & 13'h1FFF;
        settings_used++;
    endtask

    task automatic report_mismatch(input string field, input int expected_v, input int actual_v);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, expected_v, actual_v);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        if (rx_stall_left != 0) begin
            rx_stall_left <= rx_stall_left - 1;
            i_m_tready    <= 1'b0;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
            rx_stall_left <= $urandom_range(0, 12);
            i_m_tready    <= 1'b0;
        end else begin
            i_m_tready    <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            seen.status      = o_m_tdata[1:0];
            seen.page_number = o_m_tdata[13:2];
            seen.free_count  = o_m_tdata[26:14];
            seen.page_valid  = o_m_tuser;
            seen.last        = o_m_tlast;
            results_seen++;
            if (page_results_due.size() == 0) begin
                $display("%0t: response with none pending, expected nothing, actual %h",
                         $time, seen);
                mismatches++;
            end else begin
                want = page_results_due.pop_front();
                if (want.status !== seen.status)
                    report_mismatch("status", want.status, seen.status);
                if (want.page_valid !== seen.page_valid)
                    report_mismatch("page_valid", want.page_valid, seen.page_valid);
                if (want.page_number !== seen.page_number)
                    report_mismatch("page_number", want.page_number, seen.page_number);
                if (want.last !== seen.last)
                    report_mismatch("last", want.last, seen.last);
                if (want.free_count !== seen.free_count)
                    report_mismatch("free_count", want.free_count, seen.free_count);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no request or response moved for %0d cycles", $time, QUIET_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    task automatic test_default_map();
        send_request(bpa_pkg::KIND_FREE, 7'd0, 12'd100);
        send_request(bpa_pkg::KIND_ALLOC, 7'd0, 12'hFFF);
        send_request(bpa_pkg::KIND_ALLOC, 7'd64, 12'd0);
        send_request(bpa_pkg::KIND_ALLOC, 7'd127, 12'd0);
        send_request(bpa_pkg::KIND_FREE, 7'd127, 12'd4095);
    endtask

    task automatic test_small_map();
        wait_idle();
        set_config(16, 4);
        send_request(bpa_pkg::KIND_INIT, 7'd0, 12'd0);
        send_request(bpa_pkg::KIND_ALLOC, 7'd12, 12'd0);
        send_request(bpa_pkg::KIND_ALLOC, 7'd1, 12'd0);
        send_request(bpa_pkg::KIND_FREE, 7'd0, 12'd16);
        send_request(bpa_pkg::KIND_FREE, 7'd0, 12'd5);
        send_request(bpa_pkg::KIND_FREE, 7'd0, 12'd5);
        send_request(bpa_pkg::KIND_ALLOC, 7'd2, 12'd0);
        send_request(KIND_UNUSED, 7'd127, 12'hFFF);
    endtask

    task automatic test_register_extremes();
        wait_idle();
        set_config(0, 0);
        send_request(bpa_pkg::KIND_INIT, 7'd0, 12'd0);
        send_request(bpa_pkg::KIND_ALLOC, 7'd1, 12'd0);
        send_request(bpa_pkg::KIND_FREE, 7'd0, 12'd0);
        wait_idle();
        set_config(8191, 8191);
        send_request(bpa_pkg::KIND_INIT, 7'd0, 12'd0);
        send_request(bpa_pkg::KIND_FREE, 7'd0, 12'd4095);
        send_request(bpa_pkg::KIND_ALLOC, 7'd1, 12'd0);
        wait_idle();
        set_config(1, 0);
        send_request(bpa_pkg::KIND_INIT, 7'd0, 12'd0);
        send_request(bpa_pkg::KIND_ALLOC, 7'd1, 12'd0);
    endtask

    task automatic test_stale_map();
        wait_idle();
        set_config(4096, 0);
        send_request(bpa_pkg::KIND_INIT, 7'd0, 12'd0);
        wait_idle();
        set_config(8, 0);
        send_request(bpa_pkg::KIND_ALLOC, 7'd9, 12'd0);
    endtask

    task automatic run_phase(input int total, input int reserved, input int items,
                             input bit with_init, input bit idle);
        int roll;
        int sub;
        int lim;
        int idx;
        logic [bpa_pkg::COUNT_W-1:0] cnt;
        logic [bpa_pkg::PAGE_W-1:0]  pg;
        wait_idle();
        idle_en = idle;
        set_config(total, reserved);
        if (with_init)
            send_request(bpa_pkg::KIND_INIT, bpa_pkg::COUNT_W'($urandom_range(0, 127)),
                         bpa_pkg::PAGE_W'($urandom_range(0, 4095)));
        repeat (items) begin
            roll = $urandom_range(0, 99);
            sub  = $urandom_range(0, 19);
            cnt  = bpa_pkg::COUNT_W'($urandom_range(0, 127));
            pg   = bpa_pkg::PAGE_W'($urandom_range(0, 4095));
            lim  = managed_pages();
            if (roll < 45) begin
                if (sub < 14)
                    cnt = bpa_pkg::COUNT_W'($urandom_range(1, 8));
                else if (sub < 17)
                    cnt = bpa_pkg::COUNT_W'($urandom_range(9, BURST_LIMIT));
                else if (sub == 17)
                    cnt = '0;
                else if (sub == 18)
                    cnt = bpa_pkg::COUNT_W'($urandom_range(BURST_LIMIT + 1, 127));
                else
                    cnt = bpa_pkg::COUNT_W'((pages_free + 1 < 127) ?
                                            pages_free + $urandom_range(0, 1) : 127);
                send_request(bpa_pkg::KIND_ALLOC, cnt, pg);
            end else if (roll < 92) begin
                if (sub < 15 && held_pages.size() != 0) begin
                    idx = $urandom_range(0, held_pages.size() - 1);
                    pg  = bpa_pkg::PAGE_W'(held_pages[idx]);
                    held_pages.delete(idx);
                end else if (sub < 17 && lim != 0) begin
                    pg = bpa_pkg::PAGE_W'($urandom_range(0, lim - 1));
                end else if (sub < 19 && lim < MAP_PAGES) begin
                    pg = bpa_pkg::PAGE_W'($urandom_range(lim, MAP_PAGES - 1));
                end
                send_request(bpa_pkg::KIND_FREE, cnt, pg);
            end else if (roll < 96) begin
                send_request(bpa_pkg::KIND_INIT, cnt, pg);
            end else begin
                send_request(KIND_UNUSED, cnt, pg);
            end
        end
    endtask

    task automatic test_random_traffic();
        int t;
        run_phase(64, 0, 60, 1'b1, 1'b1);
        t = $urandom_range(9, 200);
        run_phase(t, $urandom_range(0, t / 2), 60, 1'b1, 1'b1);
        run_phase(1, 0, 40, 1'b1, 1'b1);
        run_phase(8191, $urandom_range(1024, 3000), 60, 1'b1, 1'b1);
        run_phase($urandom_range(100, 400), 8191, 60, 1'b1, 1'b1);
        t = $urandom_range(16, 600);
        run_phase(t, $urandom_range(0, t), 60, 1'b0, 1'b1);
        run_phase(8, 3, 60, 1'b1, 1'b0);
        run_phase(200, 50, 80, 1'b1, 1'b0);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_map();
        test_small_map();
        test_register_extremes();
        test_stale_map();
        directed_count = requests_sent;
        test_random_traffic();
        wait_idle();
        $display("Sent %0d requests (%0d directed) under %0d register settings.",
                 requests_sent, directed_count, settings_used);
        $display("Checked %0d responses; %0d field mismatches.", results_seen, mismatches);
        if (mismatches == 0 && page_results_due.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/bpa_pkg.sv
design/bpa_front.sv
design/bpa_queue.sv
design/bpa_back.sv
design/bitmap_page_allocator.sv
tb/bitmap_page_allocator_tb.sv
